// ----- rtl/core/gecv_pkg.sv -----
// Shared types and constants of the gradient eye center voting block.
package gecv_pkg;

  localparam int POS_W     = 6;
  localparam int GRAD_W    = 16;
  localparam int SCORE_W   = 48;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 2;

  localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

  localparam logic [CFG_W-1:0] GRID_WIDTH_RST  = 7'd50;
  localparam logic [CFG_W-1:0] GRID_HEIGHT_RST = 7'd40;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_WIDTH  = 2'd0,
    REG_GRID_HEIGHT = 2'd1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE,
    ST_DRAIN,
    ST_SWEEP,
    ST_FINISH,
    ST_HOLD
  } state_t;

endpackage

// ----- rtl/core/gecv_if.sv -----
// Valid/ready channel interfaces for gradient items and vote results.
interface gecv_in_if;
  logic                                valid;
  logic                                ready;
  logic        [gecv_pkg::POS_W-1:0]   pos_x;
  logic        [gecv_pkg::POS_W-1:0]   pos_y;
  logic signed [gecv_pkg::GRAD_W-1:0]  grad_x;
  logic signed [gecv_pkg::GRAD_W-1:0]  grad_y;
  logic                                last;

  modport source (output valid, pos_x, pos_y, grad_x, grad_y, last, input ready);
  modport sink   (input valid, pos_x, pos_y, grad_x, grad_y, last, output ready);
endinterface

interface gecv_out_if;
  logic                               valid;
  logic                               ready;
  logic [gecv_pkg::POS_W-1:0]         best_x;
  logic [gecv_pkg::POS_W-1:0]         best_y;
  logic [gecv_pkg::SCORE_W-1:0]       best_score;

  modport source (output valid, best_x, best_y, best_score, input ready);
  modport sink   (input valid, best_x, best_y, best_score, output ready);
endinterface

// ----- rtl/core/gecv_score_mem.sv -----
// Score accumulator memory: one write port, one registered read port.
module gecv_score_mem #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int DW    = 48
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // A read and a write to the same address in one cycle return the old data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/gecv_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, rounding done by the caller.
module gecv_div #(
  parameter int QW = 48,
  parameter int MW = 13,
  parameter int AW = 12
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_v,
  input  logic [QW-1:0] in_num,
  input  logic [MW-1:0] in_den,
  input  logic [AW-1:0] in_addr,
  output logic          out_v,
  output logic [QW-1:0] out_q,
  output logic [AW-1:0] out_addr
);

  logic          v_r    [QW];
  logic [MW-1:0] rem_r  [QW];
  logic [QW-1:0] num_r  [QW];
  logic [QW-1:0] q_r    [QW];
  logic [MW-1:0] den_r  [QW];
  logic [AW-1:0] addr_r [QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic          v_in;
    logic [MW-1:0] rem_in;
    logic [QW-1:0] num_in;
    logic [QW-1:0] q_in;
    logic [MW-1:0] den_in;
    logic [AW-1:0] addr_in;
    logic [MW:0]   trial;
    logic          ge;

    if (i == 0) begin : g_first
      assign v_in    = in_v;
      assign rem_in  = '0;
      assign num_in  = in_num;
      assign q_in    = '0;
      assign den_in  = in_den;
      assign addr_in = in_addr;
    end else begin : g_next
      assign v_in    = v_r[i-1];
      assign rem_in  = rem_r[i-1];
      assign num_in  = num_r[i-1];
      assign q_in    = q_r[i-1];
      assign den_in  = den_r[i-1];
      assign addr_in = addr_r[i-1];
    end

    assign trial = {rem_in, num_in[QW-1]};
    assign ge    = trial >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else begin
        v_r[i] <= v_in;
      end
      rem_r[i]  <= ge ? MW'(trial - {1'b0, den_in}) : MW'(trial);
      num_r[i]  <= {num_in[QW-2:0], 1'b0};
      q_r[i]    <= {q_in[QW-2:0], ge};
      den_r[i]  <= den_in;
      addr_r[i] <= addr_in;
    end
  end

  assign out_v    = v_r[QW-1];
  assign out_q    = q_r[QW-1];
  assign out_addr = addr_r[QW-1];

endmodule

// ----- rtl/core/gradient_eye_center_vote_top.sv -----
// Top level of the means-of-gradients eye center voting block.
//
//   channel   direction  fields                                   handshake
//   in_ch     in         pos_x, pos_y, grad_x, grad_y, last       valid/ready
//   out_ch    out        best_x, best_y, best_score               valid/ready
//   cfg_*     in         cfg_index, cfg_data                      cfg_we, no wait
//
// An item that votes is accepted and then steps through width*height cells, one grid cell per
// cycle through the read-modify-write port of the score memory, and then waits in the drain
// state while the vote pipeline and the divider drain. An item that does not vote is only
// accepted. A last item then adds a sweep over all MAX_DIM*MAX_DIM cells that searches and
// clears the memory, followed by the finish and hold states. After reset the memory is cleared
// by the same sweep before the first item is taken. A stalled result holds only the start of
// the next frame's result; items are taken meanwhile.
module gradient_eye_center_vote_top #(
  parameter int MAX_DIM = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  gecv_in_if.sink                       in_ch,
  gecv_out_if.source                    out_ch,
  input  logic                          cfg_we,
  input  logic [gecv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gecv_pkg::CFG_W-1:0]    cfg_data
);

  import gecv_pkg::*;

  localparam int CW    = $clog2(MAX_DIM);
  localparam int DIMW  = $clog2(MAX_DIM + 1);
  localparam int DCW   = (DIMW > CFG_W) ? DIMW : CFG_W;
  localparam int PCW   = (DIMW > POS_W) ? DIMW : POS_W;
  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int DW    = CW + 1;
  localparam int PW    = DW + GRAD_W;
  localparam int NW    = DW + GRAD_W + 1;
  localparam int MW    = 2 * CW + 1;
  localparam int QW    = 2 * NW;
  localparam int SW    = ((QW > SCORE_W) ? QW : SCORE_W) + 1;
  localparam int LAT   = QW + 8;
  localparam int LW    = $clog2(LAT + 1);
  localparam logic [CW-1:0] LAST_C = CW'(MAX_DIM - 1);

  state_t state_r, state_nxt;

  logic [CFG_W-1:0] gw_r, gh_r;
  logic [DIMW-1:0]  gw_clamp, gh_clamp;
  logic [DIMW-1:0]  gwc_r, ghc_r;

  logic [CW-1:0]            px_r, py_r;
  logic signed [GRAD_W-1:0] gx_r, gy_r;
  logic                     last_r;
  logic [CW-1:0]            cx_r, cy_r;
  logic [LW-1:0]            drain_r;

  logic in_acc, active, upd_done, sweep_done, out_load;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gw_r <= GRID_WIDTH_RST;
      gh_r <= GRID_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GRID_WIDTH:  gw_r <= cfg_data;
        REG_GRID_HEIGHT: gh_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign gw_clamp = (DCW'(gw_r) > DCW'(MAX_DIM)) ? DIMW'(MAX_DIM) : DIMW'(gw_r);
  assign gh_clamp = (DCW'(gh_r) > DCW'(MAX_DIM)) ? DIMW'(MAX_DIM) : DIMW'(gh_r);

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign active      = ((in_ch.grad_x != '0) || (in_ch.grad_y != '0)) &&
                       (PCW'(in_ch.pos_x) < PCW'(gw_clamp)) &&
                       (PCW'(in_ch.pos_y) < PCW'(gh_clamp));
  assign upd_done    = (DIMW'(cx_r) == gwc_r - 1'b1) && (DIMW'(cy_r) == ghc_r - 1'b1);
  assign sweep_done  = (cx_r == LAST_C) && (cy_r == LAST_C);
  assign out_load    = (state_r == ST_HOLD) && (!out_ch.valid || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:  if (sweep_done) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_acc) begin
          if (active) begin
            state_nxt = ST_UPDATE;
          end else if (in_ch.last) begin
            state_nxt = ST_SWEEP;
          end
        end
      end
      ST_UPDATE: if (upd_done) state_nxt = ST_DRAIN;
      ST_DRAIN: begin
        if (drain_r == '0) begin
          state_nxt = last_r ? ST_SWEEP : ST_IDLE;
        end
      end
      ST_SWEEP:  if (sweep_done) state_nxt = ST_FINISH;
      ST_FINISH: state_nxt = ST_HOLD;
      ST_HOLD:   if (out_load) state_nxt = ST_IDLE;
      default:   state_nxt = ST_CLEAR;
    endcase
  end

  // Item latch, cell counters and drain timer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r    <= '0;
      cy_r    <= '0;
      drain_r <= '0;
      last_r  <= 1'b0;
    end else begin
      if (in_acc) begin
        last_r <= in_ch.last;
        cx_r   <= '0;
        cy_r   <= '0;
      end
      unique case (state_r)
        ST_UPDATE: begin
          if (DIMW'(cx_r) == gwc_r - 1'b1) begin
            cx_r <= '0;
            cy_r <= upd_done ? '0 : cy_r + 1'b1;
          end else begin
            cx_r <= cx_r + 1'b1;
          end
          if (upd_done) begin
            drain_r <= LW'(LAT);
          end
        end
        ST_DRAIN: drain_r <= drain_r - 1'b1;
        ST_CLEAR, ST_SWEEP: begin
          if (cx_r == LAST_C) begin
            cx_r <= '0;
            cy_r <= (cy_r == LAST_C) ? '0 : cy_r + 1'b1;
          end else begin
            cx_r <= cx_r + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      px_r  <= CW'(in_ch.pos_x);
      py_r  <= CW'(in_ch.pos_y);
      gx_r  <= in_ch.grad_x;
      gy_r  <= in_ch.grad_y;
      gwc_r <= gw_clamp;
      ghc_r <= gh_clamp;
    end
  end

  // Vote pipeline: displacement, products, dot product and norm, square, numerator.
  logic                  v1_r, v2_r, v3_r, v4_r, v5_r;
  logic [AW-1:0]         a1_r, a2_r, a3_r, a4_r, a5_r;
  logic signed [DW-1:0]  dx1_r, dy1_r;
  logic signed [PW-1:0]  pxg2_r, pyg2_r;
  logic signed [2*DW-1:0] dxx2_r, dyy2_r;
  logic                  z2_r;
  logic signed [NW-1:0]  n3_r;
  logic [MW-1:0]         m3_r, m4_r, m5_r;
  logic [2*NW-3:0]       sq4_r;
  logic [QW-1:0]         num5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      v1_r <= (state_r == ST_UPDATE);
      v2_r <= v1_r;
      v3_r <= v2_r && !z2_r;
      v4_r <= v3_r && !n3_r[NW-1] && (n3_r != '0);
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    a1_r   <= AW'(cy_r * MAX_DIM + cx_r);
    dx1_r  <= $signed({1'b0, px_r}) - $signed({1'b0, cx_r});
    dy1_r  <= $signed({1'b0, py_r}) - $signed({1'b0, cy_r});
    a2_r   <= a1_r;
    pxg2_r <= dx1_r * gx_r;
    pyg2_r <= dy1_r * gy_r;
    dxx2_r <= dx1_r * dx1_r;
    dyy2_r <= dy1_r * dy1_r;
    z2_r   <= (dx1_r == '0) && (dy1_r == '0);
    a3_r   <= a2_r;
    n3_r   <= NW'(pxg2_r) + NW'(pyg2_r);
    m3_r   <= MW'(dxx2_r) + MW'(dyy2_r);
    a4_r   <= a3_r;
    sq4_r  <= n3_r[NW-2:0] * n3_r[NW-2:0];
    m4_r   <= m3_r;
    a5_r   <= a4_r;
    // Adding half the divisor rounds the quotient to nearest, ties up.
    num5_r <= {sq4_r, 2'b00} + QW'(m4_r >> 1);
    m5_r   <= m4_r;
  end

  logic          dv;
  logic [QW-1:0] dq;
  logic [AW-1:0] da;

  gecv_div #(.QW(QW), .MW(MW), .AW(AW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_v     (v5_r),
    .in_num   (num5_r),
    .in_den   (m5_r),
    .in_addr  (a5_r),
    .out_v    (dv),
    .out_q    (dq),
    .out_addr (da)
  );

  // Read-modify-write of the accumulator; each cell is visited once per item.
  logic                wb_v_r;
  logic [QW-1:0]       wb_q_r;
  logic [AW-1:0]       wb_a_r;
  logic [SW-1:0]       wb_sum;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr, mem_raddr, sweep_addr;
  logic [SCORE_W-1:0]  mem_wdata, mem_rdata;
  logic                sweeping;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb_v_r <= 1'b0;
    end else begin
      wb_v_r <= dv;
    end
    wb_q_r <= dq;
    wb_a_r <= da;
  end

  assign sweeping   = (state_r == ST_SWEEP) || (state_r == ST_CLEAR);
  assign sweep_addr = AW'(cy_r * MAX_DIM + cx_r);
  assign wb_sum     = SW'(mem_rdata) + SW'(wb_q_r);
  assign mem_raddr  = sweeping ? sweep_addr : da;
  assign mem_we     = sweeping || wb_v_r;
  assign mem_waddr  = sweeping ? sweep_addr : wb_a_r;
  assign mem_wdata  = sweeping ? '0 :
                      (wb_sum > SW'(SCORE_MAX)) ? SCORE_MAX : SCORE_W'(wb_sum);

  gecv_score_mem #(.DEPTH(DEPTH), .AW(AW), .DW(SCORE_W)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Search for the first maximum in row-major order during the sweep.
  logic               sw_v_r, sw_in_r, found_r;
  logic [CW-1:0]      sw_cx_r, sw_cy_r;
  logic [CW-1:0]      bx_r, by_r;
  logic [SCORE_W-1:0] best_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_v_r  <= 1'b0;
      found_r <= 1'b0;
    end else begin
      sw_v_r <= (state_r == ST_SWEEP);
      if (in_acc) begin
        found_r <= 1'b0;
      end else if (sw_v_r && sw_in_r && (!found_r || mem_rdata > best_r)) begin
        found_r <= 1'b1;
      end
    end
    sw_in_r <= (DIMW'(cx_r) < gwc_r) && (DIMW'(cy_r) < ghc_r);
    sw_cx_r <= cx_r;
    sw_cy_r <= cy_r;
    if (in_acc) begin
      best_r <= '0;
      bx_r   <= '0;
      by_r   <= '0;
    end else if (sw_v_r && sw_in_r && (!found_r || mem_rdata > best_r)) begin
      best_r <= mem_rdata;
      bx_r   <= sw_cx_r;
      by_r   <= sw_cy_r;
    end
  end

  // Result register.
  logic               out_v_r;
  logic [POS_W-1:0]   out_x_r, out_y_r;
  logic [SCORE_W-1:0] out_s_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_load) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
    if (out_load) begin
      out_x_r <= POS_W'(bx_r);
      out_y_r <= POS_W'(by_r);
      out_s_r <= best_r;
    end
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.best_x     = out_x_r;
  assign out_ch.best_y     = out_y_r;
  assign out_ch.best_score = out_s_r;

  a_sweep_writes_zero: assert property (@(posedge clk) disable iff (!rst_n)
    sweeping |-> (mem_we && mem_wdata == '0))
    else $error("sweep must clear the entry it reads");

  a_no_update_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (wb_v_r || dv) |-> (state_r == ST_UPDATE || state_r == ST_DRAIN))
    else $error("accumulator update outside the update and drain phases");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && active) |=> (state_r == ST_UPDATE))
    else $error("voting transaction did not start the update pass");

  a_result_after_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_v_r)
    else $error("result not presented after the search");

endmodule
